// ===== rtl/rlen_pkg.sv =====
// Shared types and codes for the ring leader election node.
`timescale 1ns / 1ps
`default_nettype none

package rlen_pkg;

    localparam int ID_BITS_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int WORD_BITS      = 16;

    localparam logic       ACT_START = 1'b0;
    localparam logic       ACT_MSG   = 1'b1;

    localparam logic [1:0] KIND_PROBE = 2'd0;
    localparam logic [1:0] KIND_ELECT = 2'd1;
    localparam logic [1:0] KIND_COUNT = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    localparam logic [1:0] ROLE_CAND   = 2'd0;
    localparam logic [1:0] ROLE_LOST   = 2'd1;
    localparam logic [1:0] ROLE_LEADER = 2'd2;

    typedef struct packed {
        logic                 action;
        logic [1:0]           kind;
        logic [WORD_BITS-1:0] word0;
        logic [WORD_BITS-1:0] word1;
    } t_item;

    typedef struct packed {
        logic                 send_valid;
        logic [1:0]           send_kind;
        logic [WORD_BITS-1:0] send_word0;
        logic [WORD_BITS-1:0] send_word1;
        logic [1:0]           role;
        logic                 report_valid;
        logic [WORD_BITS-1:0] total_received;
        logic [WORD_BITS-1:0] total_sent;
        logic                 leader_is_self;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/ring_leader_election_node_core.sv =====
// Top level of one ring leader election node: ports, input register, id register.
//
//  channel | dir | handshake              | payload
//  in      | in  | i_in_valid/o_in_ready  | action, msg_kind, msg_word0, msg_word1
//  out     | out | o_out_valid/i_out_ready| send_*, role, report_valid, totals, leader_is_self
//  cfg     | in  | i_cfg_valid/o_cfg_ready| own_id
//
// One beat per cycle sustained while the output is not stalled; a beat passes
// through the input register, then one compare/forward pass into the result register.
// Reset is synchronous, active low, and clears phase, largest id and counters;
// own_id resets to zero. A stalled output holds its beat and backs up into the
// input register; o_in_ready drops only when both stages are full.
`timescale 1ns / 1ps
`default_nettype none

module ring_leader_election_node_core
    import rlen_pkg::*;
#(
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_action,
    input  wire logic [1:0]           i_msg_kind,
    input  wire logic [WORD_BITS-1:0] i_msg_word0,
    input  wire logic [WORD_BITS-1:0] i_msg_word1,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_send_valid,
    output logic [1:0]                o_send_kind,
    output logic [WORD_BITS-1:0]      o_send_word0,
    output logic [WORD_BITS-1:0]      o_send_word1,
    output logic [1:0]                o_role,
    output logic                      o_report_valid,
    output logic [WORD_BITS-1:0]      o_total_received,
    output logic [WORD_BITS-1:0]      o_total_sent,
    output logic                      o_leader_is_self,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [WORD_BITS-1:0] i_cfg_data
);

    logic                 r_in_valid, n_in_valid;
    t_item                r_item, n_item;
    logic [WORD_BITS-1:0] r_own_id, n_own_id;
    logic                 fire;
    logic                 out_valid;
    t_result              res;

    assign fire       = r_in_valid && (!out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    always_comb begin
        n_in_valid = r_in_valid;
        n_item     = r_item;
        n_own_id   = r_own_id;
        if (o_in_ready) begin
            n_in_valid = i_in_valid;
            n_item     = '{action: i_action, kind: i_msg_kind,
                           word0: i_msg_word0, word1: i_msg_word1};
        end
        if (i_cfg_valid) begin
            n_own_id = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_own_id   <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            r_own_id   <= n_own_id;
        end
        r_item <= n_item;
    end

    rlen_engine #(
        .ID_BITS    (ID_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_item),
        .i_own_id    (r_own_id),
        .i_out_ready (i_out_ready),
        .o_out_valid (out_valid),
        .o_res       (res)
    );

    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = out_valid;
    assign o_send_valid     = res.send_valid;
    assign o_send_kind      = res.send_kind;
    assign o_send_word0     = res.send_word0;
    assign o_send_word1     = res.send_word1;
    assign o_role           = res.role;
    assign o_report_valid   = res.report_valid;
    assign o_total_received = res.total_received;
    assign o_total_sent     = res.total_sent;
    assign o_leader_is_self = res.leader_is_self;

endmodule

`default_nettype wire

// ===== rtl/rlen_engine.sv =====
// Election state machine, per-node counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module rlen_engine
    import rlen_pkg::*;
#(
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire t_item                i_item,
    input  wire logic [WORD_BITS-1:0] i_own_id,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output t_result                   o_res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CAND,
        PH_LOST,
        PH_LEADFWD,
        PH_GATHER,
        PH_TOTALS,
        PH_DONE
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [ID_BITS-1:0]    r_largest, n_largest;
    logic [COUNT_BITS-1:0] r_rcnt, n_rcnt;
    logic [COUNT_BITS-1:0] r_scnt, n_scnt;
    logic                  r_out_valid, n_out_valid;
    t_result               r_res, n_res;

    logic [ID_BITS+WORD_BITS-1:0]    me_ext, id_ext;
    logic [ID_BITS-1:0]              me, id, id_max;
    logic [1:0]                      kind;
    logic [COUNT_BITS+WORD_BITS-1:0] w0_ext, w1_ext;
    logic [COUNT_BITS-1:0]           w0_cnt, w1_cnt;
    logic [COUNT_BITS-1:0]           rcnt_inc, scnt_inc, rcnt_sum, scnt_sum;
    logic [ID_BITS+WORD_BITS-1:0]    me_word_ext;
    logic [WORD_BITS-1:0]            me_word;

    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] a,
        input logic [COUNT_BITS-1:0] b
    );
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic [WORD_BITS-1:0] cnt_word(input logic [COUNT_BITS-1:0] c);
        logic [COUNT_BITS+WORD_BITS-1:0] x;
        x = {{WORD_BITS{1'b0}}, c};
        return x[WORD_BITS-1:0];
    endfunction

    assign me_ext      = {{ID_BITS{1'b0}}, i_own_id};
    assign id_ext      = {{ID_BITS{1'b0}}, i_item.word0};
    assign me          = me_ext[ID_BITS-1:0];
    assign id          = id_ext[ID_BITS-1:0];
    assign id_max      = (id > r_largest) ? id : r_largest;
    assign me_word_ext = {{WORD_BITS{1'b0}}, me};
    assign me_word     = me_word_ext[WORD_BITS-1:0];
    assign kind        = (i_item.kind == KIND_RSVD) ? KIND_PROBE : i_item.kind;
    assign w0_ext      = {{COUNT_BITS{1'b0}}, i_item.word0};
    assign w1_ext      = {{COUNT_BITS{1'b0}}, i_item.word1};
    assign w0_cnt      = w0_ext[COUNT_BITS-1:0];
    assign w1_cnt      = w1_ext[COUNT_BITS-1:0];
    assign rcnt_inc    = sat_add(r_rcnt, COUNT_BITS'(1));
    assign scnt_inc    = sat_add(r_scnt, COUNT_BITS'(1));
    assign rcnt_sum    = (kind == KIND_COUNT) ? sat_add(r_rcnt, w0_cnt) : r_rcnt;
    assign scnt_sum    = (kind == KIND_COUNT) ? sat_add(r_scnt, w1_cnt) : r_scnt;

    always_comb begin
        n_phase     = r_phase;
        n_largest   = r_largest;
        n_rcnt      = r_rcnt;
        n_scnt      = r_scnt;
        n_out_valid = i_fire ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
        n_res       = r_res;
        if (i_fire) begin
            n_res = '0;
            if (i_item.action == ACT_START) begin
                if (r_phase == PH_IDLE) begin
                    n_largest        = me;
                    n_phase          = PH_CAND;
                    n_res.send_valid = 1'b1;
                    n_res.send_kind  = KIND_PROBE;
                    n_res.send_word0 = me_word;
                    n_scnt           = scnt_inc;
                end
            end else begin
                unique case (r_phase)
                    PH_CAND: begin
                        n_rcnt = rcnt_inc;
                        if (kind == KIND_ELECT || id > r_largest) begin
                            n_largest        = id;
                            n_phase          = PH_LOST;
                            n_res.send_valid = 1'b1;
                            n_res.send_kind  = kind;
                            n_res.send_word0 = i_item.word0;
                            n_res.send_word1 = i_item.word1;
                            n_scnt           = scnt_inc;
                        end else if (id == me) begin
                            n_largest        = me;
                            n_phase          = PH_LEADFWD;
                            n_res.send_valid = 1'b1;
                            n_res.send_kind  = KIND_ELECT;
                            n_res.send_word0 = me_word;
                            n_scnt           = scnt_inc;
                        end
                    end
                    PH_LOST, PH_LEADFWD: begin
                        n_rcnt           = rcnt_inc;
                        n_res.send_valid = 1'b1;
                        if (r_phase == PH_LOST && kind == KIND_ELECT) begin
                            n_largest        = id_max;
                            n_res.send_kind  = kind;
                            n_res.send_word0 = i_item.word0;
                            n_res.send_word1 = i_item.word1;
                            n_scnt           = scnt_inc;
                            n_phase          = PH_GATHER;
                        end else if (r_phase == PH_LEADFWD && kind == KIND_ELECT
                                     && id == me) begin
                            n_largest        = id_max;
                            n_res.send_kind  = KIND_COUNT;
                            n_res.send_word0 = cnt_word(rcnt_inc);
                            n_res.send_word1 = cnt_word(r_scnt);
                            n_phase          = PH_TOTALS;
                        end else begin
                            n_res.send_kind  = kind;
                            n_res.send_word0 = i_item.word0;
                            n_res.send_word1 = i_item.word1;
                            n_scnt           = scnt_inc;
                        end
                    end
                    PH_GATHER: begin
                        n_res.send_valid = 1'b1;
                        n_res.send_kind  = KIND_COUNT;
                        n_res.send_word0 = cnt_word(rcnt_sum);
                        n_res.send_word1 = cnt_word(scnt_sum);
                        n_phase          = PH_DONE;
                    end
                    PH_TOTALS: begin
                        if (kind == KIND_COUNT) begin
                            n_res.report_valid   = 1'b1;
                            n_res.total_received = i_item.word0;
                            n_res.total_sent     = i_item.word1;
                            n_phase              = PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (n_phase == PH_LEADFWD || n_phase == PH_TOTALS
                || (n_phase == PH_DONE && n_largest == me && n_res.report_valid)) begin
                n_res.role = ROLE_LEADER;
            end else if (n_phase == PH_LOST || n_phase == PH_GATHER) begin
                n_res.role = ROLE_LOST;
            end else begin
                n_res.role = ROLE_CAND;
            end
            n_res.leader_is_self = (n_largest == me);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_largest   <= '0;
            r_rcnt      <= '0;
            r_scnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_largest   <= n_largest;
            r_rcnt      <= n_rcnt;
            r_scnt      <= n_scnt;
            r_out_valid <= n_out_valid;
        end
        r_res <= n_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ===== rtl/rlen_checker.sv =====
// Port-level assertions for the ring leader election node, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rlen_checker
    import rlen_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic                 o_send_valid,
    input wire logic [1:0]           o_send_kind,
    input wire logic [WORD_BITS-1:0] o_send_word0,
    input wire logic [WORD_BITS-1:0] o_send_word1,
    input wire logic                 o_report_valid,
    input wire logic [WORD_BITS-1:0] o_total_received,
    input wire logic [WORD_BITS-1:0] o_total_sent
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_send_word0) && $stable(o_send_word1)
            && $stable(o_send_kind) && $stable(o_report_valid))
        else $error("result beat changed while stalled");

    // no message means all-zero message words
    a_send_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_send_valid |->
            o_send_kind == KIND_PROBE && o_send_word0 == '0 && o_send_word1 == '0)
        else $error("message fields nonzero without send");

    // totals only with a report
    a_total_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_report_valid |->
            o_total_received == '0 && o_total_sent == '0)
        else $error("totals nonzero without report");

    // the final report ends the run: nothing is sent alongside
    a_report_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_report_valid |-> !o_send_valid)
        else $error("message sent with report");

endmodule

bind ring_leader_election_node_core rlen_checker u_rlen_checker (.*);

`default_nettype wire
